FILE: hw/rtl/tdfs_pkg.sv
// Types, codes and constants shared by the tank drain/fill sequencer files.
package tdfs_pkg;

    localparam int LEVEL_W = 4;
    localparam int SECS_W  = 16;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_ABORT = 3'd2;
    localparam logic [2:0] OP_REARM = 3'd3;
    localparam logic [2:0] OP_LOAD  = 3'd4;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_ARMED    = 3'd1;
    localparam logic [2:0] PH_DRAIN    = 3'd2;
    localparam logic [2:0] PH_FILL     = 3'd3;
    localparam logic [2:0] PH_COMPLETE = 3'd4;
    localparam logic [2:0] PH_ABORTED  = 3'd5;

    localparam logic [1:0] KIND_FULL  = 2'd0;
    localparam logic [1:0] KIND_DRAIN = 2'd1;
    localparam logic [1:0] KIND_FILL  = 2'd2;
    localparam logic [1:0] KIND_ALIAS = 2'd3;

    localparam logic [1:0] REASON_END     = 2'd0;
    localparam logic [1:0] REASON_TIMEOUT = 2'd1;
    localparam logic [1:0] REASON_ABORT   = 2'd2;

    localparam logic [2:0] REG_KIND         = 3'd0;
    localparam logic [2:0] REG_ENABLED      = 3'd1;
    localparam logic [2:0] REG_HOLD_CHEM    = 3'd2;
    localparam logic [2:0] REG_WINDOW       = 3'd3;
    localparam logic [2:0] REG_DRAIN_TARGET = 3'd4;
    localparam logic [2:0] REG_FILL_TARGET  = 3'd5;
    localparam logic [2:0] REG_DRAIN_TMO    = 3'd6;
    localparam logic [2:0] REG_FILL_TMO     = 3'd7;

    localparam logic [SECS_W-1:0]  DEFAULT_TIMEOUT = SECS_W'(1800);
    localparam logic [LEVEL_W-1:0] FILL_TARGET_RST = '1;

    typedef struct packed {
        logic [1:0]         run_kind;
        logic               rule_enabled;
        logic               dose_hold;
        logic               window_active;
        logic [LEVEL_W-1:0] drain_target_level;
        logic [LEVEL_W-1:0] fill_target_level;
        logic [SECS_W-1:0]  drain_timeout_s;
        logic [SECS_W-1:0]  fill_timeout_s;
    } t_cfg;

    typedef struct packed {
        logic [2:0]        phase;
        logic              start_pending;
        logic              window_seen;
        logic              drain_active;
        logic              fill_active;
        logic              gate;
        logic              finish_reported;
        logic [SECS_W-1:0] phase_seconds;
    } t_state;

    typedef struct packed {
        logic       accepted;
        logic [2:0] phase_code;
        logic       drain_relay_on;
        logic       fill_relay_on;
        logic       gate_held;
        logic       finished_event;
        logic       finished_status;
        logic [1:0] finished_reason;
    } t_result;

endpackage

FILE: hw/rtl/tdfs_if.sv
// Command and result channel interfaces of the tank drain/fill sequencer.
interface tdfs_op_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   operation;
    logic [tdfs_pkg::LEVEL_W-1:0] tank_level;
    logic                         in_window;
    logic                         second_pulse;

    modport source (output valid, output operation, output tank_level, output in_window,
                    output second_pulse, input ready);
    modport sink (input valid, input operation, input tank_level, input in_window,
                  input second_pulse, output ready);
endinterface

interface tdfs_res_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic [2:0] phase_code;
    logic       drain_relay_on;
    logic       fill_relay_on;
    logic       gate_held;
    logic       finished_event;
    logic       finished_status;
    logic [1:0] finished_reason;

    modport source (output valid, output accepted, output phase_code, output drain_relay_on,
                    output fill_relay_on, output gate_held, output finished_event,
                    output finished_status, output finished_reason, input ready);
    modport sink (input valid, input accepted, input phase_code, input drain_relay_on,
                  input fill_relay_on, input gate_held, input finished_event,
                  input finished_status, input finished_reason, output ready);
endinterface

FILE: hw/rtl/tdfs_step.sv
// Next-state and result logic of the sequencer for one command or tick.
module tdfs_step (
    input  tdfs_pkg::t_cfg                 i_cfg,
    input  tdfs_pkg::t_state               i_state,
    input  logic [2:0]                     i_operation,
    input  logic [tdfs_pkg::LEVEL_W-1:0]   i_tank_level,
    input  logic                           i_in_window,
    input  logic                           i_second_pulse,
    output tdfs_pkg::t_state               o_state,
    output tdfs_pkg::t_result              o_result
);

    typedef struct packed {
        tdfs_pkg::t_state st;
        logic             done;
    } t_run;

    function automatic t_run enter_fill(tdfs_pkg::t_state st, logic at_fill);
        t_run r;
        r.st               = st;
        r.done             = 1'b0;
        r.st.phase         = tdfs_pkg::PH_FILL;
        r.st.phase_seconds = '0;
        if (at_fill) begin
            r.st.drain_active    = 1'b0;
            r.st.fill_active     = 1'b0;
            r.st.gate            = 1'b0;
            r.st.phase           = tdfs_pkg::PH_COMPLETE;
            r.st.finish_reported = 1'b1;
            r.done               = 1'b1;
        end else begin
            r.st.fill_active = 1'b1;
        end
        return r;
    endfunction

    function automatic t_run begin_run(tdfs_pkg::t_state st, logic hold, logic [1:0] kind,
                                       logic at_drain, logic at_fill);
        t_run r;
        r.st   = st;
        r.done = 1'b0;
        if (hold) begin
            r.st.gate = 1'b1;
        end
        r.st.finish_reported = 1'b0;
        if (kind == tdfs_pkg::KIND_FILL) begin
            r = enter_fill(r.st, at_fill);
        end else begin
            r.st.phase         = tdfs_pkg::PH_DRAIN;
            r.st.phase_seconds = '0;
            if (at_drain) begin
                r.st.drain_active = 1'b0;
                if (kind == tdfs_pkg::KIND_DRAIN) begin
                    r.st.gate            = 1'b0;
                    r.st.phase           = tdfs_pkg::PH_COMPLETE;
                    r.st.finish_reported = 1'b1;
                    r.done               = 1'b1;
                end else begin
                    r = enter_fill(r.st, at_fill);
                end
            end else begin
                r.st.drain_active = 1'b1;
            end
        end
        return r;
    endfunction

    tdfs_pkg::t_state          n_st;
    t_run                      run;
    logic [1:0]                kind;
    logic                      inw;
    logic                      at_drain;
    logic                      at_fill;
    logic                      armed;
    logic                      running;
    logic                      draining;
    logic [tdfs_pkg::SECS_W-1:0] secs_inc;
    logic [tdfs_pkg::SECS_W-1:0] tmo_reg;
    logic [tdfs_pkg::SECS_W-1:0] tmo_limit;
    logic                      acc;
    logic                      fin_req;
    logic                      fin_prior;
    logic                      fin_status;
    logic [1:0]                fin_reason;
    logic                      fire;

    assign kind      = (i_cfg.run_kind == tdfs_pkg::KIND_ALIAS) ? tdfs_pkg::KIND_DRAIN
                                                                : i_cfg.run_kind;
    assign inw       = i_cfg.window_active ? i_in_window : 1'b1;
    assign at_drain  = (i_tank_level == i_cfg.drain_target_level);
    assign at_fill   = (i_tank_level == i_cfg.fill_target_level);
    assign armed     = (i_state.phase == tdfs_pkg::PH_ARMED);
    assign draining  = (i_state.phase == tdfs_pkg::PH_DRAIN);
    assign running   = draining || (i_state.phase == tdfs_pkg::PH_FILL);
    assign secs_inc  = (i_second_pulse && (i_state.phase_seconds != '1))
                       ? i_state.phase_seconds + 1'b1 : i_state.phase_seconds;
    assign tmo_reg   = draining ? i_cfg.drain_timeout_s : i_cfg.fill_timeout_s;
    assign tmo_limit = (tmo_reg == '0) ? tdfs_pkg::DEFAULT_TIMEOUT : tmo_reg;

    always_comb begin
        n_st       = i_state;
        run        = '0;
        acc        = 1'b0;
        fin_req    = 1'b0;
        fin_prior  = i_state.finish_reported;
        fin_status = 1'b0;
        fin_reason = tdfs_pkg::REASON_END;
        unique case (i_operation)
            tdfs_pkg::OP_TICK: begin
                acc = 1'b1;
                if (!i_cfg.rule_enabled && armed) begin
                    n_st.phase         = tdfs_pkg::PH_IDLE;
                    n_st.phase_seconds = '0;
                end else if (armed && i_state.start_pending) begin
                    n_st.start_pending = 1'b0;
                    run       = begin_run(n_st, i_cfg.dose_hold, kind, at_drain, at_fill);
                    n_st      = run.st;
                    fin_req   = run.done;
                    fin_prior = 1'b0;
                end else if (armed && i_cfg.window_active && inw && !i_state.window_seen) begin
                    run              = begin_run(n_st, i_cfg.dose_hold, kind, at_drain,
                                                 at_fill);
                    n_st             = run.st;
                    n_st.window_seen = inw;
                    fin_req          = run.done;
                    fin_prior        = 1'b0;
                end else begin
                    n_st.window_seen = inw;
                    if (running) begin
                        n_st.phase_seconds = secs_inc;
                        if (secs_inc >= tmo_limit) begin
                            n_st.drain_active  = 1'b0;
                            n_st.fill_active   = 1'b0;
                            n_st.gate          = 1'b0;
                            n_st.phase         = tdfs_pkg::PH_ABORTED;
                            n_st.phase_seconds = '0;
                            fin_req            = 1'b1;
                            fin_status         = 1'b1;
                            fin_reason         = tdfs_pkg::REASON_TIMEOUT;
                        end else if (draining ? at_drain : at_fill) begin
                            if (draining && (kind == tdfs_pkg::KIND_FULL)) begin
                                n_st.drain_active = 1'b0;
                                run     = enter_fill(n_st, at_fill);
                                n_st    = run.st;
                                fin_req = run.done;
                            end else begin
                                if (draining) begin
                                    n_st.drain_active = 1'b0;
                                end else begin
                                    n_st.fill_active = 1'b0;
                                end
                                n_st.gate          = 1'b0;
                                n_st.phase         = tdfs_pkg::PH_COMPLETE;
                                n_st.phase_seconds = '0;
                                fin_req            = 1'b1;
                            end
                        end else if (draining) begin
                            n_st.drain_active = 1'b1;
                        end else begin
                            n_st.fill_active = 1'b1;
                        end
                    end
                end
            end
            tdfs_pkg::OP_START: begin
                if (armed && i_cfg.rule_enabled) begin
                    n_st.finish_reported = 1'b0;
                    n_st.start_pending   = 1'b1;
                    acc                  = 1'b1;
                end
            end
            tdfs_pkg::OP_ABORT: begin
                if (running) begin
                    n_st.drain_active  = 1'b0;
                    n_st.fill_active   = 1'b0;
                    n_st.gate          = 1'b0;
                    n_st.phase         = tdfs_pkg::PH_ABORTED;
                    n_st.phase_seconds = '0;
                    fin_req            = 1'b1;
                    fin_status         = 1'b1;
                    fin_reason         = tdfs_pkg::REASON_ABORT;
                    acc                = 1'b1;
                end
            end
            tdfs_pkg::OP_REARM: begin
                if ((i_state.phase == tdfs_pkg::PH_COMPLETE) ||
                    (i_state.phase == tdfs_pkg::PH_ABORTED)) begin
                    n_st.phase_seconds = '0;
                    if (!i_cfg.rule_enabled) begin
                        n_st.phase = tdfs_pkg::PH_IDLE;
                    end else begin
                        n_st.finish_reported = 1'b0;
                        n_st.start_pending   = 1'b0;
                        n_st.phase           = tdfs_pkg::PH_ARMED;
                    end
                    acc = 1'b1;
                end
            end
            tdfs_pkg::OP_LOAD: begin
                n_st.gate            = 1'b0;
                n_st.drain_active    = 1'b0;
                n_st.fill_active     = 1'b0;
                n_st.phase           = i_cfg.rule_enabled ? tdfs_pkg::PH_ARMED
                                                          : tdfs_pkg::PH_IDLE;
                n_st.phase_seconds   = '0;
                n_st.finish_reported = 1'b0;
                n_st.start_pending   = 1'b0;
                n_st.window_seen     = inw;
                acc                  = 1'b1;
            end
            default: begin
            end
        endcase
        fire = fin_req && !fin_prior;
        if (fire) begin
            n_st.finish_reported = 1'b1;
        end
    end

    assign o_state                  = n_st;
    assign o_result.accepted        = acc;
    assign o_result.phase_code      = n_st.phase;
    assign o_result.drain_relay_on  = n_st.drain_active;
    assign o_result.fill_relay_on   = n_st.fill_active;
    assign o_result.gate_held       = n_st.gate;
    assign o_result.finished_event  = fire;
    assign o_result.finished_status = fire ? fin_status : 1'b0;
    assign o_result.finished_reason = fire ? fin_reason : tdfs_pkg::REASON_END;

endmodule

FILE: hw/rtl/tank_drain_fill_sequencer.sv
// Top level of the tank drain/fill sequencer: config registers, state and output buffer.
//
// One command or tick is taken per clock while the skid entry is free; its result is
// registered and offered on the result channel. The phase update is a combinational pass
// from the state registers through the step logic, and a two-entry output buffer keeps
// input transfers going for one more item while a result is stalled. The user must write
// configuration through the APB port only while the block is idle; the block itself does
// not enforce this. Registers read back at any time; no clearing pass follows reset.
module tank_drain_fill_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tdfs_op_if.sink                        i_op,
    tdfs_res_if.source                     o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tdfs_pkg::PADDR_W-1:0]   paddr,
    input  logic [tdfs_pkg::PDATA_W-1:0]   pwdata,
    output logic [tdfs_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    tdfs_pkg::t_cfg    r_cfg;
    tdfs_pkg::t_state  r_state;
    tdfs_pkg::t_state  n_state;
    tdfs_pkg::t_result step_result;
    tdfs_pkg::t_result r_out;
    tdfs_pkg::t_result r_skid;
    logic              r_out_valid;
    logic              r_skid_valid;
    logic              n_out_valid;
    logic              n_skid_valid;
    logic              in_xfer;
    logic              out_xfer;
    logic              cfg_wr;
    logic [2:0]        reg_idx;

    tdfs_step u_step (
        .i_cfg          (r_cfg),
        .i_state        (r_state),
        .i_operation    (i_op.operation),
        .i_tank_level   (i_op.tank_level),
        .i_in_window    (i_op.in_window),
        .i_second_pulse (i_op.second_pulse),
        .o_state        (n_state),
        .o_result       (step_result)
    );

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[tdfs_pkg::PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.run_kind           <= tdfs_pkg::KIND_FULL;
            r_cfg.rule_enabled       <= 1'b1;
            r_cfg.dose_hold          <= 1'b1;
            r_cfg.window_active      <= 1'b0;
            r_cfg.drain_target_level <= '0;
            r_cfg.fill_target_level  <= tdfs_pkg::FILL_TARGET_RST;
            r_cfg.drain_timeout_s    <= tdfs_pkg::DEFAULT_TIMEOUT;
            r_cfg.fill_timeout_s     <= tdfs_pkg::DEFAULT_TIMEOUT;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                tdfs_pkg::REG_KIND:         r_cfg.run_kind           <= pwdata[1:0];
                tdfs_pkg::REG_ENABLED:      r_cfg.rule_enabled       <= pwdata[0];
                tdfs_pkg::REG_HOLD_CHEM:    r_cfg.dose_hold          <= pwdata[0];
                tdfs_pkg::REG_WINDOW:       r_cfg.window_active      <= pwdata[0];
                tdfs_pkg::REG_DRAIN_TARGET: begin
                    r_cfg.drain_target_level <= pwdata[tdfs_pkg::LEVEL_W-1:0];
                end
                tdfs_pkg::REG_FILL_TARGET: begin
                    r_cfg.fill_target_level <= pwdata[tdfs_pkg::LEVEL_W-1:0];
                end
                tdfs_pkg::REG_DRAIN_TMO:    r_cfg.drain_timeout_s <= pwdata[tdfs_pkg::SECS_W-1:0];
                tdfs_pkg::REG_FILL_TMO:     r_cfg.fill_timeout_s  <= pwdata[tdfs_pkg::SECS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            tdfs_pkg::REG_KIND:         prdata[1:0] = r_cfg.run_kind;
            tdfs_pkg::REG_ENABLED:      prdata[0]   = r_cfg.rule_enabled;
            tdfs_pkg::REG_HOLD_CHEM:    prdata[0]   = r_cfg.dose_hold;
            tdfs_pkg::REG_WINDOW:       prdata[0]   = r_cfg.window_active;
            tdfs_pkg::REG_DRAIN_TARGET: prdata[tdfs_pkg::LEVEL_W-1:0] = r_cfg.drain_target_level;
            tdfs_pkg::REG_FILL_TARGET:  prdata[tdfs_pkg::LEVEL_W-1:0] = r_cfg.fill_target_level;
            tdfs_pkg::REG_DRAIN_TMO:    prdata[tdfs_pkg::SECS_W-1:0]  = r_cfg.drain_timeout_s;
            tdfs_pkg::REG_FILL_TMO:     prdata[tdfs_pkg::SECS_W-1:0]  = r_cfg.fill_timeout_s;
            default: begin
            end
        endcase
    end

    assign i_op.ready = !r_skid_valid;
    assign in_xfer    = i_op.valid && !r_skid_valid;
    assign out_xfer   = r_out_valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (out_xfer) begin
            n_out_valid  = r_skid_valid || in_xfer;
            n_skid_valid = 1'b0;
        end else if (in_xfer) begin
            n_out_valid  = 1'b1;
            n_skid_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // hold payload while stalled; refill from the skid entry first
    always_ff @(posedge i_clk) begin
        if (out_xfer || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : step_result;
        end
        if (in_xfer && r_out_valid && !out_xfer) begin
            r_skid <= step_result;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.accepted        = r_out.accepted;
    assign o_res.phase_code      = r_out.phase_code;
    assign o_res.drain_relay_on  = r_out.drain_relay_on;
    assign o_res.fill_relay_on   = r_out.fill_relay_on;
    assign o_res.gate_held       = r_out.gate_held;
    assign o_res.finished_event  = r_out.finished_event;
    assign o_res.finished_status = r_out.finished_status;
    assign o_res.finished_reason = r_out.finished_reason;

endmodule

FILE: hw/rtl/tdfs_chk.sv
// Port-level assertion checker for the tank drain/fill sequencer and its bind.
module tdfs_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic [2:0] i_phase_code,
    input logic       i_drain_relay_on,
    input logic       i_fill_relay_on,
    input logic       i_finished_event,
    input logic       i_finished_status,
    input logic [1:0] i_finished_reason
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_phase_code)
            && $stable(i_finished_event) && $stable(i_finished_reason))
        else $error("result changed while stalled");

    a_event_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_finished_event |->
            (i_phase_code == tdfs_pkg::PH_COMPLETE) || (i_phase_code == tdfs_pkg::PH_ABORTED))
        else $error("finished event outside a finished phase");

    a_relay_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |->
            (!i_drain_relay_on || (i_phase_code == tdfs_pkg::PH_DRAIN)) &&
            (!i_fill_relay_on || (i_phase_code == tdfs_pkg::PH_FILL)))
        else $error("relay driven outside its phase");

    a_event_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |->
            (i_finished_event || (!i_finished_status &&
                                  (i_finished_reason == tdfs_pkg::REASON_END))) &&
            (i_finished_status || (i_finished_reason == tdfs_pkg::REASON_END)) &&
            (!i_finished_status || (i_phase_code == tdfs_pkg::PH_ABORTED)))
        else $error("finished status and reason disagree");

endmodule

bind tank_drain_fill_sequencer tdfs_chk u_tdfs_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_phase_code      (o_res.phase_code),
    .i_drain_relay_on  (o_res.drain_relay_on),
    .i_fill_relay_on   (o_res.fill_relay_on),
    .i_finished_event  (o_res.finished_event),
    .i_finished_status (o_res.finished_status),
    .i_finished_reason (o_res.finished_reason)
);

FILE: test/tdfs_phase_checker.sv
// Checker for the tank drain/fill sequencer: predicts every result and compares transfers.
`timescale 1ns / 100ps
module tdfs_phase_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    tdfs_op_if                           i_op,
    tdfs_res_if                          i_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tdfs_pkg::PADDR_W-1:0] paddr,
    input  logic [tdfs_pkg::PDATA_W-1:0] pwdata,
    input  logic                         pready,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_checked,
    output int                           o_finishes
);

    tdfs_pkg::t_cfg    cfg;
    tdfs_pkg::t_state  tank;
    logic              fin_event;
    logic              fin_status;
    logic [1:0]        fin_reason;
    tdfs_pkg::t_result predicted_outputs[$];
    tdfs_pkg::t_result seen;
    tdfs_pkg::t_result want;
    tdfs_pkg::t_result pred;
    int                fail_total = 0;
    int                checked_total = 0;
    int                finish_total = 0;

    function automatic logic [1:0] kind_now();
        return (cfg.run_kind == tdfs_pkg::KIND_ALIAS) ? tdfs_pkg::KIND_DRAIN : cfg.run_kind;
    endfunction

    function automatic void enter_phase(input logic [2:0] ph);
        tank.phase         = ph;
        tank.phase_seconds = '0;
    endfunction

    function automatic void report_finish(input logic status, input logic [1:0] reason);
        if (!tank.finish_reported) begin
            tank.finish_reported = 1'b1;
            fin_event            = 1'b1;
            fin_status           = status;
            fin_reason           = reason;
        end
    endfunction

    function automatic void complete_run();
        tank.gate = 1'b0;
        enter_phase(tdfs_pkg::PH_COMPLETE);
        report_finish(1'b0, tdfs_pkg::REASON_END);
    endfunction

    function automatic void abort_run(input logic [1:0] reason);
        tank.drain_active = 1'b0;
        tank.fill_active  = 1'b0;
        tank.gate         = 1'b0;
        enter_phase(tdfs_pkg::PH_ABORTED);
        report_finish(1'b1, reason);
    endfunction

    function automatic void enter_fill(input logic [tdfs_pkg::LEVEL_W-1:0] level);
        enter_phase(tdfs_pkg::PH_FILL);
        if (level == cfg.fill_target_level) begin
            tank.drain_active = 1'b0;
            tank.fill_active  = 1'b0;
            complete_run();
        end else begin
            tank.fill_active = 1'b1;
        end
    endfunction

    function automatic void begin_run(input logic [tdfs_pkg::LEVEL_W-1:0] level);
        if (cfg.dose_hold)
            tank.gate = 1'b1;
        tank.finish_reported = 1'b0;
        if (kind_now() == tdfs_pkg::KIND_FILL) begin
            enter_fill(level);
        end else begin
            enter_phase(tdfs_pkg::PH_DRAIN);
            if (level == cfg.drain_target_level) begin
                tank.drain_active = 1'b0;
                if (kind_now() == tdfs_pkg::KIND_DRAIN)
                    complete_run();
                else
                    enter_fill(level);
            end else begin
                tank.drain_active = 1'b1;
            end
        end
    endfunction

    function automatic tdfs_pkg::t_result advance_sequencer(
        input logic [2:0] op, input logic [tdfs_pkg::LEVEL_W-1:0] level,
        input logic win, input logic pulse);
        tdfs_pkg::t_result           r;
        logic                        inw;
        logic                        draining;
        logic [tdfs_pkg::SECS_W-1:0] limit;
        r          = '0;
        fin_event  = 1'b0;
        fin_status = 1'b0;
        fin_reason = tdfs_pkg::REASON_END;
        case (op)
            tdfs_pkg::OP_TICK: begin
                r.accepted = 1'b1;
                inw = cfg.window_active ? win : 1'b1;
                if (!cfg.rule_enabled && tank.phase == tdfs_pkg::PH_ARMED) begin
                    enter_phase(tdfs_pkg::PH_IDLE);
                end else if (tank.phase == tdfs_pkg::PH_ARMED && tank.start_pending) begin
                    tank.start_pending = 1'b0;
                    begin_run(level);
                end else if (tank.phase == tdfs_pkg::PH_ARMED && cfg.window_active && inw
                             && !tank.window_seen) begin
                    begin_run(level);
                    tank.window_seen = inw;
                end else begin
                    tank.window_seen = inw;
                    if (tank.phase == tdfs_pkg::PH_DRAIN || tank.phase == tdfs_pkg::PH_FILL)
                    begin
                        draining = (tank.phase == tdfs_pkg::PH_DRAIN);
                        if (pulse && tank.phase_seconds != '1)
                            tank.phase_seconds = tank.phase_seconds + 1'b1;
                        limit = draining ? cfg.drain_timeout_s : cfg.fill_timeout_s;
                        if (limit == '0)
                            limit = tdfs_pkg::DEFAULT_TIMEOUT;
                        if (tank.phase_seconds >= limit) begin
                            abort_run(tdfs_pkg::REASON_TIMEOUT);
                        end else if (level == (draining ? cfg.drain_target_level
                                                        : cfg.fill_target_level)) begin
                            if (draining) begin
                                tank.drain_active = 1'b0;
                                if (kind_now() == tdfs_pkg::KIND_FULL)
                                    enter_fill(level);
                                else
                                    complete_run();
                            end else begin
                                tank.fill_active = 1'b0;
                                complete_run();
                            end
                        end else if (draining) begin
                            tank.drain_active = 1'b1;
                        end else begin
                            tank.fill_active = 1'b1;
                        end
                    end
                end
            end
            tdfs_pkg::OP_START: begin
                if (tank.phase == tdfs_pkg::PH_ARMED && cfg.rule_enabled) begin
                    tank.finish_reported = 1'b0;
                    tank.start_pending   = 1'b1;
                    r.accepted           = 1'b1;
                end
            end
            tdfs_pkg::OP_ABORT: begin
                if (tank.phase == tdfs_pkg::PH_DRAIN || tank.phase == tdfs_pkg::PH_FILL) begin
                    abort_run(tdfs_pkg::REASON_ABORT);
                    r.accepted = 1'b1;
                end
            end
            tdfs_pkg::OP_REARM: begin
                if (tank.phase == tdfs_pkg::PH_COMPLETE || tank.phase == tdfs_pkg::PH_ABORTED)
                begin
                    if (!cfg.rule_enabled) begin
                        enter_phase(tdfs_pkg::PH_IDLE);
                    end else begin
                        tank.finish_reported = 1'b0;
                        tank.start_pending   = 1'b0;
                        enter_phase(tdfs_pkg::PH_ARMED);
                    end
                    r.accepted = 1'b1;
                end
            end
            tdfs_pkg::OP_LOAD: begin
                tank.gate         = 1'b0;
                tank.drain_active = 1'b0;
                tank.fill_active  = 1'b0;
                enter_phase(cfg.rule_enabled ? tdfs_pkg::PH_ARMED : tdfs_pkg::PH_IDLE);
                tank.finish_reported = 1'b0;
                tank.start_pending   = 1'b0;
                tank.window_seen     = cfg.window_active ? win : 1'b1;
                r.accepted           = 1'b1;
            end
            default: ;
        endcase
        r.phase_code      = tank.phase;
        r.drain_relay_on  = tank.drain_active;
        r.fill_relay_on   = tank.fill_active;
        r.gate_held       = tank.gate;
        r.finished_event  = fin_event;
        r.finished_status = fin_status;
        r.finished_reason = fin_reason;
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", field, want_v, got_v);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.run_kind           = tdfs_pkg::KIND_FULL;
            cfg.rule_enabled       = 1'b1;
            cfg.dose_hold          = 1'b1;
            cfg.window_active      = 1'b0;
            cfg.drain_target_level = '0;
            cfg.fill_target_level  = tdfs_pkg::FILL_TARGET_RST;
            cfg.drain_timeout_s    = tdfs_pkg::DEFAULT_TIMEOUT;
            cfg.fill_timeout_s     = tdfs_pkg::DEFAULT_TIMEOUT;
            tank       = '0;
            tank.phase = tdfs_pkg::PH_IDLE;
            predicted_outputs.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                seen.accepted        = i_res.accepted;
                seen.phase_code      = i_res.phase_code;
                seen.drain_relay_on  = i_res.drain_relay_on;
                seen.fill_relay_on   = i_res.fill_relay_on;
                seen.gate_held       = i_res.gate_held;
                seen.finished_event  = i_res.finished_event;
                seen.finished_status = i_res.finished_status;
                seen.finished_reason = i_res.finished_reason;
                if (predicted_outputs.size() == 0) begin
                    $error("result transfer with phase_code %0d but no prediction waiting",
                           seen.phase_code);
                    fail_total++;
                end else begin
                    want = predicted_outputs.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(seen.accepted));
                    check_field("phase_code", 32'(want.phase_code), 32'(seen.phase_code));
                    check_field("drain_relay_on", 32'(want.drain_relay_on),
                                32'(seen.drain_relay_on));
                    check_field("fill_relay_on", 32'(want.fill_relay_on),
                                32'(seen.fill_relay_on));
                    check_field("gate_held", 32'(want.gate_held), 32'(seen.gate_held));
                    check_field("finished_event", 32'(want.finished_event),
                                32'(seen.finished_event));
                    check_field("finished_status", 32'(want.finished_status),
                                32'(seen.finished_status));
                    check_field("finished_reason", 32'(want.finished_reason),
                                32'(seen.finished_reason));
                    checked_total++;
                    if (want.finished_event)
                        finish_total++;
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[tdfs_pkg::PADDR_W-1:2])
                    tdfs_pkg::REG_KIND:         cfg.run_kind           = pwdata[1:0];
                    tdfs_pkg::REG_ENABLED:      cfg.rule_enabled       = pwdata[0];
                    tdfs_pkg::REG_HOLD_CHEM:    cfg.dose_hold          = pwdata[0];
                    tdfs_pkg::REG_WINDOW:       cfg.window_active      = pwdata[0];
                    tdfs_pkg::REG_DRAIN_TARGET: begin
                        cfg.drain_target_level = pwdata[tdfs_pkg::LEVEL_W-1:0];
                    end
                    tdfs_pkg::REG_FILL_TARGET: begin
                        cfg.fill_target_level = pwdata[tdfs_pkg::LEVEL_W-1:0];
                    end
                    tdfs_pkg::REG_DRAIN_TMO: cfg.drain_timeout_s = pwdata[tdfs_pkg::SECS_W-1:0];
                    tdfs_pkg::REG_FILL_TMO:  cfg.fill_timeout_s  = pwdata[tdfs_pkg::SECS_W-1:0];
                    default: ;
                endcase
            end
            if (i_op.valid && i_op.ready) begin
                pred = advance_sequencer(i_op.operation, i_op.tank_level, i_op.in_window,
                                         i_op.second_pulse);
                predicted_outputs.insert(predicted_outputs.size(), pred);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= predicted_outputs.size();
        o_checked    <= checked_total;
        o_finishes   <= finish_total;
    end

endmodule

FILE: test/tb_tank_drain_fill_sequencer.sv
// Testbench top for the tank drain/fill sequencer: stimulus, configuration and verdict.
`timescale 1ns / 100ps
module tb_tank_drain_fill_sequencer;

    localparam int         LVL_W          = tdfs_pkg::LEVEL_W;
    localparam int         SEC_W          = tdfs_pkg::SECS_W;
    localparam int         DAT_W          = tdfs_pkg::PDATA_W;
    localparam int         CLK_PERIOD     = 20;
    localparam int         RESET_CYCLES   = 7;
    localparam int         CYCLE_LIMIT    = 1_000_000;
    localparam int         SETTLE_CYCLES  = 4;
    localparam int         ZERO_TMO_TICKS = 40;

    localparam logic [1:0] STALL_NONE   = 2'd0;
    localparam logic [1:0] STALL_RANDOM = 2'd1;
    localparam logic [1:0] STALL_TOGGLE = 2'd2;
    localparam logic [1:0] STALL_HOLD   = 2'd3;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [tdfs_pkg::PADDR_W-1:0] paddr;
    logic [DAT_W-1:0]             pwdata;
    logic [DAT_W-1:0]             prdata;
    logic                         pready;

    int fail_count;
    int pending;
    int checked;
    int finishes;
    int items_sent  = 0;
    int cfg_writes  = 0;
    int burst_left  = 0;
    int cycle_count = 0;
    int stall_span  = 0;
    int pulse_pct   = 30;

    logic [1:0]       stall_mode = STALL_NONE;
    logic [LVL_W-1:0] drain_tgt  = '0;
    logic [LVL_W-1:0] fill_tgt   = '1;

    tdfs_op_if  op_if();
    tdfs_res_if res_if();

    tank_drain_fill_sequencer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tdfs_phase_checker phase_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op_if),
        .i_res        (res_if),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_finishes   (finishes)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode <= 2'($urandom_range(0, 3));
            stall_span <= $urandom_range(8, 40);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            STALL_NONE:   res_if.ready <= 1'b1;
            STALL_RANDOM: res_if.ready <= ($urandom_range(0, 3) != 0);
            STALL_TOGGLE: res_if.ready <= stall_span[0];
            STALL_HOLD:   res_if.ready <= 1'b0;
        endcase
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [LVL_W-1:0] rand_level();
        case ($urandom_range(0, 3))
            0:       return drain_tgt;
            1:       return fill_tgt;
            default: return LVL_W'($urandom_range(0, 15));
        endcase
    endfunction

    function automatic logic pulse_now();
        return ($urandom_range(0, 99) < pulse_pct);
    endfunction

    task automatic apb_write(input logic [2:0] idx, input logic [DAT_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_writes++;
    endtask

    task automatic configure(input logic [1:0] kind, input logic en, input logic hold,
                             input logic win, input logic [LVL_W-1:0] dtgt,
                             input logic [LVL_W-1:0] ftgt, input logic [SEC_W-1:0] dtmo,
                             input logic [SEC_W-1:0] ftmo);
        apb_write(tdfs_pkg::REG_KIND, DAT_W'(kind));
        apb_write(tdfs_pkg::REG_ENABLED, DAT_W'(en));
        apb_write(tdfs_pkg::REG_HOLD_CHEM, DAT_W'(hold));
        apb_write(tdfs_pkg::REG_WINDOW, DAT_W'(win));
        apb_write(tdfs_pkg::REG_DRAIN_TARGET, DAT_W'(dtgt));
        apb_write(tdfs_pkg::REG_FILL_TARGET, DAT_W'(ftgt));
        apb_write(tdfs_pkg::REG_DRAIN_TMO, DAT_W'(dtmo));
        apb_write(tdfs_pkg::REG_FILL_TMO, DAT_W'(ftmo));
        drain_tgt = dtgt;
        fill_tgt  = ftgt;
    endtask

    task automatic send_item(input logic [2:0] op, input logic [LVL_W-1:0] level,
                             input logic win, input logic pulse);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                op_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        op_if.valid        <= 1'b1;
        op_if.operation    <= op;
        op_if.tank_level   <= level;
        op_if.in_window    <= win;
        op_if.second_pulse <= pulse;
        do @(posedge i_clk); while (!op_if.ready);
        items_sent++;
    endtask

    // hold off until every predicted result has been taken, then let the block settle
    task automatic wait_drained();
        op_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic run_random(input int n);
        int   stop_at;
        int   ticks;
        logic win;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            win = 1'($urandom_range(0, 1));
            send_item(tdfs_pkg::OP_LOAD, rand_level(), win, pulse_now());
            if ($urandom_range(0, 2) != 0)
                send_item(tdfs_pkg::OP_START, rand_level(), win, pulse_now());
            ticks = $urandom_range(2, 24);
            repeat (ticks) begin
                if ($urandom_range(0, 3) == 0)
                    win = ~win;
                case ($urandom_range(0, 19))
                    0: send_item(tdfs_pkg::OP_ABORT, rand_level(), win, pulse_now());
                    1: send_item(tdfs_pkg::OP_START, rand_level(), win, pulse_now());
                    2: send_item(3'($urandom_range(0, 7)), LVL_W'($urandom_range(0, 15)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    default: send_item(tdfs_pkg::OP_TICK, rand_level(), win, pulse_now());
                endcase
            end
            if ($urandom_range(0, 3) != 0)
                send_item(tdfs_pkg::OP_REARM, rand_level(), win, pulse_now());
        end
    endtask

    initial begin
        logic [2:0]       spare;
        logic [LVL_W-1:0] lvl;
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        op_if.valid        = 1'b0;
        op_if.operation    = tdfs_pkg::OP_TICK;
        op_if.tank_level   = '0;
        op_if.in_window    = 1'b0;
        op_if.second_pulse = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // commands out of phase, unknown codes, one full drain-and-fill run, an aborted run, a new start
        send_item(tdfs_pkg::OP_TICK, 4'd0, 1'b0, 1'b0);
        send_item(tdfs_pkg::OP_START, 4'd15, 1'b1, 1'b1);
        send_item(tdfs_pkg::OP_ABORT, 4'd0, 1'b0, 1'b0);
        send_item(tdfs_pkg::OP_REARM, 4'd15, 1'b1, 1'b0);
        for (spare = tdfs_pkg::OP_LOAD + 3'd1; spare != tdfs_pkg::OP_TICK; spare++)
            send_item(spare, 4'd15, 1'b1, 1'b1);
        send_item(tdfs_pkg::OP_LOAD, 4'd9, 1'b1, 1'b0);
        send_item(tdfs_pkg::OP_START, 4'd9, 1'b0, 1'b1);
        send_item(tdfs_pkg::OP_TICK, 4'd5, 1'b0, 1'b1);
        send_item(tdfs_pkg::OP_TICK, 4'd5, 1'b1, 1'b1);
        send_item(tdfs_pkg::OP_TICK, 4'd0, 1'b0, 1'b0);
        send_item(tdfs_pkg::OP_START, 4'd0, 1'b0, 1'b0);
        send_item(tdfs_pkg::OP_REARM, 4'd0, 1'b0, 1'b0);
        send_item(tdfs_pkg::OP_TICK, 4'd15, 1'b0, 1'b1);
        send_item(tdfs_pkg::OP_TICK, 4'd15, 1'b0, 1'b0);
        send_item(tdfs_pkg::OP_REARM, 4'd3, 1'b0, 1'b0);
        send_item(tdfs_pkg::OP_START, 4'd3, 1'b0, 1'b0);
        send_item(tdfs_pkg::OP_TICK, 4'd0, 1'b0, 1'b0);
        send_item(tdfs_pkg::OP_ABORT, 4'd7, 1'b0, 1'b0);
        send_item(tdfs_pkg::OP_ABORT, 4'd7, 1'b0, 1'b0);
        send_item(tdfs_pkg::OP_REARM, 4'd7, 1'b0, 1'b0);
        send_item(tdfs_pkg::OP_START, 4'd7, 1'b0, 1'b0);
        send_item(tdfs_pkg::OP_TICK, 4'd15, 1'b1, 1'b1);
        wait_drained();

        configure(tdfs_pkg::KIND_FULL, 1'b1, 1'b1, 1'b0, 4'd3, 4'd12, 16'd40, 16'd40);
        run_random(230);
        wait_drained();

        pulse_pct = 50;
        configure(tdfs_pkg::KIND_DRAIN, 1'b1, 1'b0, 1'b1, 4'd15, 4'd0, 16'd3, 16'd65535);
        run_random(190);
        wait_drained();

        pulse_pct = 40;
        configure(tdfs_pkg::KIND_FILL, 1'b1, 1'b1, 1'b1, LVL_W'($urandom_range(0, 15)),
                  LVL_W'($urandom_range(0, 15)), 16'd2, 16'd1);
        run_random(190);
        wait_drained();

        pulse_pct = 50;
        configure(tdfs_pkg::KIND_ALIAS, 1'b1, 1'b0, 1'b0, 4'd0, 4'd15, 16'd65535, 16'd5);
        run_random(140);
        wait_drained();

        pulse_pct = 35;
        configure(2'($urandom_range(0, 3)), 1'b1, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), LVL_W'($urandom_range(0, 15)),
                  LVL_W'($urandom_range(0, 15)), SEC_W'($urandom_range(1, 30)),
                  SEC_W'($urandom_range(1, 30)));
        run_random(200);
        wait_drained();

        // disable mid-run, then while armed
        configure(tdfs_pkg::KIND_FULL, 1'b1, 1'b1, 1'b0, 4'd0, 4'd15, 16'd100, 16'd100);
        send_item(tdfs_pkg::OP_LOAD, 4'd7, 1'b0, 1'b0);
        send_item(tdfs_pkg::OP_START, 4'd7, 1'b0, 1'b0);
        send_item(tdfs_pkg::OP_TICK, 4'd7, 1'b0, 1'b1);
        wait_drained();
        apb_write(tdfs_pkg::REG_ENABLED, DAT_W'(1'b0));
        send_item(tdfs_pkg::OP_TICK, 4'd7, 1'b0, 1'b1);
        send_item(tdfs_pkg::OP_ABORT, 4'd7, 1'b0, 1'b0);
        send_item(tdfs_pkg::OP_REARM, 4'd7, 1'b0, 1'b0);
        send_item(tdfs_pkg::OP_START, 4'd7, 1'b0, 1'b0);
        send_item(tdfs_pkg::OP_LOAD, 4'd7, 1'b0, 1'b0);
        wait_drained();
        apb_write(tdfs_pkg::REG_ENABLED, DAT_W'(1'b1));
        send_item(tdfs_pkg::OP_LOAD, 4'd7, 1'b0, 1'b0);
        wait_drained();
        apb_write(tdfs_pkg::REG_ENABLED, DAT_W'(1'b0));
        send_item(tdfs_pkg::OP_TICK, 4'd7, 1'b0, 1'b0);
        run_random(80);
        wait_drained();

        // zero timeout stands for the default, so the drain keeps running
        configure(tdfs_pkg::KIND_DRAIN, 1'b1, 1'b1, 1'b0, 4'd5, 4'd15, 16'd0, 16'd0);
        send_item(tdfs_pkg::OP_LOAD, 4'd9, 1'b0, 1'b0);
        send_item(tdfs_pkg::OP_START, 4'd9, 1'b0, 1'b0);
        repeat (ZERO_TMO_TICKS) begin
            lvl = LVL_W'($urandom_range(0, 14));
            if (lvl >= drain_tgt)
                lvl++;
            send_item(tdfs_pkg::OP_TICK, lvl, 1'($urandom_range(0, 1)), 1'b1);
        end
        wait_drained();

        $display("Checked %0d result transfers (%0d finish events) from %0d items, %0d writes",
                 checked, finishes, items_sent, cfg_writes);
        $display("Covered all procedure kinds, disabled rules, zero timeouts and stalls");
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
